### hdl/ipc_pkg.sv
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared types, codes and helpers of the IP packet type classifier.
// ----------------------------------------------------------------------------
package ipc_pkg;

  typedef enum logic [3:0] {
    CLS_ERROR = 4'd0,
    CLS_NULL  = 4'd1,
    CLS_TCP   = 4'd2,
    CLS_SYN   = 4'd3,
    CLS_ACK   = 4'd4,
    CLS_FTP   = 4'd5,
    CLS_UDP   = 4'd6,
    CLS_DNS   = 4'd7,
    CLS_ICMP  = 4'd8,
    CLS_HIGH  = 4'd9
  } class_t;

  localparam logic CFG_FTP_PORT = 1'b0;
  localparam logic CFG_DNS_PORT = 1'b1;

  localparam logic [15:0] FTP_PORT_RESET = 16'd21;
  localparam logic [15:0] DNS_PORT_RESET = 16'd53;

  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

  localparam logic [3:0] VER_IPV4 = 4'h4;
  localparam logic [3:0] VER_IPV6 = 4'h6;

  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam logic [15:0] MIN_PKT_LEN  = 16'd20;
  localparam logic [16:0] IPV6_HDR_LEN = 17'd40;
  localparam logic [16:0] TCP_MIN_LEN  = 17'd20;
  localparam logic [16:0] L4_MIN_LEN   = 17'd8;
  localparam logic [15:0] UDP_MIN_LEN  = 16'd8;
  localparam logic [15:0] FRAG_MASK    = 16'h1FFF;
  localparam logic [7:0]  TCP_FLAG_MASK = 8'h3F;
  localparam int unsigned FLAG_SYN     = 1;
  localparam int unsigned FLAG_ACK     = 4;

  localparam logic [7:0] ICMP_ECHO_REQ   = 8'd8;
  localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;
  localparam logic [7:0] ICMP6_ECHO_REQ  = 8'd128;
  localparam logic [7:0] ICMP6_ECHO_REP  = 8'd129;

  typedef struct packed {
    logic [15:0] byte_count;
    logic [7:0]  version_ihl;
    logic [15:0] ip_length;
    logic [7:0]  next_protocol;
    logic [15:0] fragment;
    logic [7:0]  l4_first;
    logic [15:0] l4_dest_port;
    logic [15:0] udp_length;
    logic [7:0]  tcp_offset;
    logic [7:0]  tcp_flags;
    logic        priority_high;
  } hdr_t;

  // L4 offset: 40 for IPv6, IHL*4 otherwise
  function automatic logic [5:0] head_len(input logic [7:0] vb);
    logic [5:0] h;
    if (vb[7:4] == VER_IPV6) begin
      h = 6'd40;
    end else begin
      h = {vb[3:0], 2'b00};
    end
    return h;
  endfunction

endpackage

### hdl/ip_packet_type_classifier.sv
// ----------------------------------------------------------------------------
// ip_packet_type_classifier
// Classifies IPv4/IPv6 packets streamed one byte per transaction.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one packet byte per transaction, with
// last_byte marking the final byte and priority_high sampled on that byte.
// Output channel (out_valid/out_ready): one packet_class transaction per
// packet, issued after its last byte.
// Throughput: one byte per cycle while in_ready is high. The capture stage
// updates the header field registers and the byte counter each byte; the last
// byte loads a snapshot register, and the class decision is taken from it into
// the result register, which drives packet_class and out_valid.
// A stalled receiver holds the result; one more packet can finish into the
// snapshot register, after which in_ready drops until out_ready returns.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 FTP control
// port, 1 DNS server port). The user must write only while the block is idle;
// the block itself does not enforce this.
// Reset (rst, synchronous): clears the packet state and both valid flags and
// restores the ports to 21 and 53.
// ----------------------------------------------------------------------------
module ip_packet_type_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  packet_byte,
  input  logic        last_byte,
  input  logic        priority_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  packet_class
);

  logic [15:0]   ftp_control_port;
  logic [15:0]   dns_server_port;
  logic          snap_valid;
  logic          snap_ready;
  ipc_pkg::hdr_t snap;

  always_ff @(posedge clk) begin
    if (rst) begin
      ftp_control_port <= ipc_pkg::FTP_PORT_RESET;
      dns_server_port  <= ipc_pkg::DNS_PORT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ipc_pkg::CFG_FTP_PORT: ftp_control_port <= cfg_data;
        ipc_pkg::CFG_DNS_PORT: dns_server_port  <= cfg_data;
      endcase
    end
  end

  ipc_capture u_capture (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .packet_byte   (packet_byte),
    .last_byte     (last_byte),
    .priority_high (priority_high),
    .snap_valid    (snap_valid),
    .snap_ready    (snap_ready),
    .snap          (snap)
  );

  ipc_classify u_classify (
    .clk              (clk),
    .rst              (rst),
    .snap_valid       (snap_valid),
    .snap_ready       (snap_ready),
    .snap             (snap),
    .ftp_control_port (ftp_control_port),
    .dns_server_port  (dns_server_port),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .packet_class     (packet_class)
  );

endmodule

### hdl/ipc_capture.sv
// ----------------------------------------------------------------------------
// ipc_capture
// Byte counter and header field capture; snapshots the fields on last byte.
// ----------------------------------------------------------------------------
module ipc_capture (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       packet_byte,
  input  logic             last_byte,
  input  logic             priority_high,
  output logic             snap_valid,
  input  logic             snap_ready,
  output ipc_pkg::hdr_t    snap
);

  ipc_pkg::hdr_t state;
  ipc_pkg::hdr_t state_next;
  logic [7:0]    ver_byte;
  logic          v6;
  logic [15:0]   pos;
  logic [15:0]   h;
  logic          accept;

  assign in_ready = !snap_valid || snap_ready;
  assign accept   = in_valid && in_ready;
  assign pos      = state.byte_count;
  assign ver_byte = (pos == 16'd0) ? packet_byte : state.version_ihl;
  assign v6       = (ver_byte[7:4] == ipc_pkg::VER_IPV6);
  assign h        = {10'd0, ipc_pkg::head_len(ver_byte)};

  always_comb begin
    state_next = state;
    state_next.priority_high = priority_high;
    if (pos != ipc_pkg::COUNT_MAX) begin
      state_next.byte_count  = pos + 16'd1;
      state_next.version_ihl = ver_byte;
      if ((!v6 && pos == 16'd2) || (v6 && pos == 16'd4)) begin
        state_next.ip_length[15:8] = packet_byte;
      end
      if ((!v6 && pos == 16'd3) || (v6 && pos == 16'd5)) begin
        state_next.ip_length[7:0] = packet_byte;
      end
      if ((!v6 && pos == 16'd9) || (v6 && pos == 16'd6)) begin
        state_next.next_protocol = packet_byte;
      end
      if (pos == 16'd6) state_next.fragment[15:8] = packet_byte;
      if (pos == 16'd7) state_next.fragment[7:0]  = packet_byte;
      if (pos == h) state_next.l4_first = packet_byte;
      if (pos == h + 16'd2) state_next.l4_dest_port[15:8] = packet_byte;
      if (pos == h + 16'd3) state_next.l4_dest_port[7:0]  = packet_byte;
      if (pos == h + 16'd4) state_next.udp_length[15:8]   = packet_byte;
      if (pos == h + 16'd5) state_next.udp_length[7:0]    = packet_byte;
      if (pos == h + 16'd12) state_next.tcp_offset = packet_byte;
      if (pos == h + 16'd13) state_next.tcp_flags  = packet_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= '0;
      snap_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (last_byte) begin
          state <= '0;
        end else begin
          state <= state_next;
        end
      end
      if (accept && last_byte) begin
        snap_valid <= 1'b1;
      end else if (snap_ready) begin
        snap_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      snap <= state_next;
    end
  end

endmodule

### hdl/ipc_classify.sv
// ----------------------------------------------------------------------------
// ipc_classify
// Class decision from the captured header fields, held in the result register.
// ----------------------------------------------------------------------------
module ipc_classify (
  input  logic             clk,
  input  logic             rst,
  input  logic             snap_valid,
  output logic             snap_ready,
  input  ipc_pkg::hdr_t    snap,
  input  logic [15:0]      ftp_control_port,
  input  logic [15:0]      dns_server_port,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [3:0]       packet_class
);

  ipc_pkg::class_t cls;
  logic [16:0]     n;
  logic [16:0]     h;
  logic [16:0]     total;
  logic [16:0]     thl_h;
  logic [7:0]      flags;
  logic [3:0]      ver;

  assign snap_ready = !out_valid || out_ready;
  assign ver   = snap.version_ihl[7:4];
  assign n     = {1'b0, snap.byte_count};
  assign h     = {11'd0, ipc_pkg::head_len(snap.version_ihl)};
  assign total = (ver == ipc_pkg::VER_IPV6) ? {1'b0, snap.ip_length} + ipc_pkg::IPV6_HDR_LEN
                                            : {1'b0, snap.ip_length};
  assign thl_h = h + {11'd0, snap.tcp_offset[7:4], 2'b00};
  assign flags = snap.tcp_flags & ipc_pkg::TCP_FLAG_MASK;

  always_comb begin
    cls = ipc_pkg::CLS_NULL;
    if (snap.byte_count <= ipc_pkg::MIN_PKT_LEN) begin
      cls = ipc_pkg::CLS_ERROR;
    end else if (ver != ipc_pkg::VER_IPV4 && ver != ipc_pkg::VER_IPV6) begin
      cls = ipc_pkg::CLS_ERROR;
    end else if (snap.priority_high) begin
      cls = ipc_pkg::CLS_HIGH;
    end else if (n < total || total < h) begin
      cls = ipc_pkg::CLS_ERROR;
    end else begin
      unique case (snap.next_protocol)
        ipc_pkg::PROTO_TCP: begin
          if (n < h + ipc_pkg::TCP_MIN_LEN || n < thl_h) begin
            cls = ipc_pkg::CLS_ERROR;
          end else if (total == thl_h) begin
            if (flags[ipc_pkg::FLAG_SYN]) cls = ipc_pkg::CLS_SYN;
            else if (flags[ipc_pkg::FLAG_ACK]) cls = ipc_pkg::CLS_ACK;
            else cls = ipc_pkg::CLS_TCP;
          end else if (snap.l4_dest_port == ftp_control_port) begin
            cls = ipc_pkg::CLS_FTP;
          end else begin
            cls = ipc_pkg::CLS_TCP;
          end
        end
        ipc_pkg::PROTO_UDP: begin
          if (n < h + ipc_pkg::L4_MIN_LEN || snap.udp_length < ipc_pkg::UDP_MIN_LEN) begin
            cls = ipc_pkg::CLS_ERROR;
          end else if (snap.l4_dest_port == dns_server_port) begin
            cls = ipc_pkg::CLS_DNS;
          end else begin
            cls = ipc_pkg::CLS_UDP;
          end
        end
        ipc_pkg::PROTO_ICMP: begin
          if (n < h + ipc_pkg::L4_MIN_LEN) begin
            cls = ipc_pkg::CLS_ERROR;
          end else if ((snap.fragment & ipc_pkg::FRAG_MASK) != 16'd0) begin
            cls = ipc_pkg::CLS_NULL;
          end else if (snap.l4_first == ipc_pkg::ICMP_ECHO_REQ ||
                       snap.l4_first == ipc_pkg::ICMP_ECHO_REPLY) begin
            cls = ipc_pkg::CLS_ICMP;
          end else begin
            cls = ipc_pkg::CLS_NULL;
          end
        end
        ipc_pkg::PROTO_ICMPV6: begin
          if (n < h + ipc_pkg::L4_MIN_LEN) begin
            cls = ipc_pkg::CLS_ERROR;
          end else if (snap.l4_first == ipc_pkg::ICMP6_ECHO_REQ ||
                       snap.l4_first == ipc_pkg::ICMP6_ECHO_REP) begin
            cls = ipc_pkg::CLS_ICMP;
          end else begin
            cls = ipc_pkg::CLS_NULL;
          end
        end
        default: begin
          cls = ipc_pkg::CLS_NULL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_ready) begin
      out_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready && snap_valid) begin
      packet_class <= cls;
    end
  end

endmodule

### tb/ip_packet_type_classifier_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_packet_type_classifier_checker
// Watches the byte, result and port-register traffic of the classifier. It
// captures the header fields of each packet as the bytes go by, works out the
// class code when the last byte is taken, and compares every result
// transaction against the oldest outstanding class.
// ----------------------------------------------------------------------------
module ip_packet_type_classifier_checker
  import ipc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  packet_byte,
  input  logic        last_byte,
  input  logic        priority_high,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  packet_class,
  output int          errors,
  output int          pending,
  output int          checked
);

  logic [15:0] ftp_port;
  logic [15:0] dns_port;

  logic [15:0] seen_bytes;
  logic [7:0]  ver_ihl;
  logic [15:0] ip_len;
  logic [7:0]  proto;
  logic [15:0] frag;
  logic [7:0]  l4_type;
  logic [15:0] dst_port;
  logic [15:0] udp_len;
  logic [7:0]  tcp_doff;
  logic [7:0]  tcp_flags;

  class_t      class_q[$];
  class_t      want;

  function automatic int unsigned l4_offset(input logic [7:0] vb);
    if (vb[7:4] == VER_IPV6) return 40;
    return vb[3:0] * 4;
  endfunction

  task automatic clear_header();
    seen_bytes = '0;
    ver_ihl    = '0;
    ip_len     = '0;
    proto      = '0;
    frag       = '0;
    l4_type    = '0;
    dst_port   = '0;
    udp_len    = '0;
    tcp_doff   = '0;
    tcp_flags  = '0;
  endtask

  // fields are taken from their fixed offsets; with a short IHL the L4 offsets
  // land inside the IP header and grab those bytes
  task automatic capture_byte(input logic [7:0] b);
    int unsigned pos;
    int unsigned h;
    bit          v6;
    pos = seen_bytes;
    if (pos == 0) ver_ihl = b;
    v6 = (ver_ihl[7:4] == VER_IPV6);
    h  = l4_offset(ver_ihl);
    if (!v6 && pos == 2) ip_len[15:8] = b;
    if (!v6 && pos == 3) ip_len[7:0] = b;
    if (v6 && pos == 4) ip_len[15:8] = b;
    if (v6 && pos == 5) ip_len[7:0] = b;
    if ((!v6 && pos == 9) || (v6 && pos == 6)) proto = b;
    if (pos == 6) frag[15:8] = b;
    if (pos == 7) frag[7:0] = b;
    if (pos == h) l4_type = b;
    if (pos == h + 2) dst_port[15:8] = b;
    if (pos == h + 3) dst_port[7:0] = b;
    if (pos == h + 4) udp_len[15:8] = b;
    if (pos == h + 5) udp_len[7:0] = b;
    if (pos == h + 12) tcp_doff = b;
    if (pos == h + 13) tcp_flags = b;
  endtask

  function automatic class_t predict_class(input logic prio);
    int unsigned n;
    int unsigned h;
    int unsigned total;
    int unsigned thl;
    logic [7:0]  flags;
    n = seen_bytes;
    if (n <= MIN_PKT_LEN) return CLS_ERROR;
    if (ver_ihl[7:4] != VER_IPV4 && ver_ihl[7:4] != VER_IPV6) return CLS_ERROR;
    if (prio) return CLS_HIGH;
    h = l4_offset(ver_ihl);
    // IPv6 total is payload length plus the fixed header, no 16-bit wrap
    if (ver_ihl[7:4] == VER_IPV6) total = ip_len + IPV6_HDR_LEN;
    else total = ip_len;
    if (n < total || total < h) return CLS_ERROR;
    case (proto)
      PROTO_TCP: begin
        if (n < h + TCP_MIN_LEN) return CLS_ERROR;
        thl = tcp_doff[7:4] * 4;
        if (n < thl + h) return CLS_ERROR;
        if (total == thl + h) begin
          flags = tcp_flags & TCP_FLAG_MASK;
          if (flags[FLAG_SYN]) return CLS_SYN;
          if (flags[FLAG_ACK]) return CLS_ACK;
          return CLS_TCP;
        end
        if (dst_port == ftp_port) return CLS_FTP;
        return CLS_TCP;
      end
      PROTO_UDP: begin
        if (n < h + L4_MIN_LEN) return CLS_ERROR;
        if (udp_len < UDP_MIN_LEN) return CLS_ERROR;
        if (dst_port == dns_port) return CLS_DNS;
        return CLS_UDP;
      end
      PROTO_ICMP: begin
        if (n < h + L4_MIN_LEN) return CLS_ERROR;
        if ((frag & FRAG_MASK) != 0) return CLS_NULL;
        if (l4_type == ICMP_ECHO_REQ || l4_type == ICMP_ECHO_REPLY) return CLS_ICMP;
        return CLS_NULL;
      end
      PROTO_ICMPV6: begin
        if (n < h + L4_MIN_LEN) return CLS_ERROR;
        if (l4_type == ICMP6_ECHO_REQ || l4_type == ICMP6_ECHO_REP) return CLS_ICMP;
        return CLS_NULL;
      end
      default: return CLS_NULL;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ftp_port = FTP_PORT_RESET;
      dns_port = DNS_PORT_RESET;
      clear_header();
      class_q.delete();
      errors  = 0;
      checked = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FTP_PORT) ftp_port = cfg_data;
        else if (cfg_index == CFG_DNS_PORT) dns_port = cfg_data;
      end
      if (in_valid && in_ready) begin
        if (seen_bytes != COUNT_MAX) begin
          capture_byte(packet_byte);
          seen_bytes = seen_bytes + 16'd1;
        end
        if (last_byte) begin
          class_q.push_back(predict_class(priority_high));
          clear_header();
        end
      end
      if (out_valid && out_ready) begin
        if (class_q.size() == 0) begin
          report_mismatch($sformatf("class %0d with no packet outstanding", packet_class));
        end else begin
          want = class_q.pop_front();
          checked++;
          if (packet_class !== want)
            report_mismatch($sformatf("packet_class %0d, expected %0d", packet_class, want));
        end
      end
    end
    pending = class_q.size();
  end

endmodule

### tb/ip_packet_type_classifier_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_packet_type_classifier_test
// Streams IPv4/IPv6 packets into the classifier byte by byte: a directed set
// that hits each class code and length corner, two 64 KiB packets that run
// the byte counter into saturation, then random packets under several port
// settings. Both channels stall at random; the checker scores the results.
// ----------------------------------------------------------------------------
module ip_packet_type_classifier_test;
  import ipc_pkg::*;

  localparam logic [7:0] PROTO_OTHER     = 8'hFF;
  localparam logic [7:0] ICMP_TYPE_OTHER = 8'hFF;

  typedef struct packed {
    logic        v6;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [15:0] dport;
    logic [7:0]  l4_type;
    logic [3:0]  doff;
    logic [7:0]  flags;
    logic [15:0] ulen;
    logic [15:0] frag;
    logic [15:0] body;
    logic [7:0]  len_add;
    logic [15:0] len_sub;
    logic [7:0]  trim;
    logic        prio;
    logic        bad_ver;
    logic        junk;
  } pkt_spec_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  packet_byte;
  logic        last_byte;
  logic        priority_high;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  packet_class;

  int          errors;
  int          pending;
  int          checked;

  bit          steady;
  logic [15:0] cur_ftp;
  logic [15:0] cur_dns;
  logic [7:0]  frame[$];
  int          sent_pkts;
  int          sent_bytes;
  int          settings;

  ip_packet_type_classifier dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .packet_byte   (packet_byte),
    .last_byte     (last_byte),
    .priority_high (priority_high),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .packet_class  (packet_class)
  );

  ip_packet_type_classifier_checker class_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .packet_byte   (packet_byte),
    .last_byte     (last_byte),
    .priority_high (priority_high),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .packet_class  (packet_class),
    .errors        (errors),
    .pending       (pending),
    .checked       (checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 21);
  end

  function automatic pkt_spec_t plain_spec(input logic v6, input logic [7:0] proto);
    pkt_spec_t s;
    s         = '0;
    s.v6      = v6;
    s.ihl     = 4'd5;
    s.proto   = proto;
    s.dport   = $urandom_range(1024, 65535);
    s.l4_type = ICMP_ECHO_REQ;
    s.doff    = 4'd5;
    s.ulen    = UDP_MIN_LEN;
    return s;
  endfunction

  function automatic pkt_spec_t random_spec();
    pkt_spec_t   s;
    logic        v6;
    logic [7:0]  proto;
    int unsigned pick;
    v6   = ($urandom_range(2) == 0);
    pick = $urandom_range(99);
    if (pick < 35) proto = PROTO_TCP;
    else if (pick < 60) proto = PROTO_UDP;
    else if (pick < 75) proto = v6 ? PROTO_ICMPV6 : PROTO_ICMP;
    else if (pick < 85) proto = v6 ? PROTO_ICMP : PROTO_ICMPV6;
    else proto = $urandom;
    s = plain_spec(v6, proto);
    if ($urandom_range(4) == 0) s.ihl = $urandom;
    if ($urandom_range(2) == 0) s.doff = $urandom;
    s.flags = $urandom;
    case ($urandom_range(3))
      0: s.flags = (s.flags & ~TCP_FLAG_MASK) | (8'd1 << FLAG_SYN);
      1: s.flags = (s.flags & ~TCP_FLAG_MASK) | (8'd1 << FLAG_ACK);
      2: s.flags = s.flags & ~TCP_FLAG_MASK;
      default: ;
    endcase
    if ($urandom_range(9) < 3) s.dport = (proto == PROTO_TCP) ? cur_ftp : cur_dns;
    else s.dport = $urandom;
    if ($urandom_range(9) == 0) s.ulen = $urandom_range(7);
    else s.ulen = $urandom_range(8, 65535);
    case ($urandom_range(4))
      0: s.l4_type = ICMP_ECHO_REQ;
      1: s.l4_type = ICMP_ECHO_REPLY;
      2: s.l4_type = ICMP6_ECHO_REQ;
      3: s.l4_type = ICMP6_ECHO_REP;
      default: s.l4_type = $urandom;
    endcase
    if ($urandom_range(9) < 7) s.frag = $urandom_range(7) * 16'h2000;
    else s.frag = $urandom;
    if ($urandom_range(1) == 1) s.body = $urandom_range(1, 12);
    pick = $urandom_range(99);
    if (pick < 8) s.len_add = $urandom_range(1, 5);
    else if (pick < 15) s.len_sub = $urandom_range(1, 70);
    else if (pick < 20) begin
      s.len_add = $urandom;
      s.len_sub = $urandom;
    end
    if ($urandom_range(99) < 6) s.trim = $urandom_range(1, 20);
    s.prio    = ($urandom_range(99) < 8);
    s.bad_ver = ($urandom_range(99) < 4);
    if ($urandom_range(99) < 6) begin
      s.junk = 1'b1;
      s.body = $urandom_range(45);
    end
    return s;
  endfunction

  task automatic put_byte(input int unsigned idx, input logic [7:0] b);
    if (idx < frame.size()) frame[idx] = b;
  endtask

  task automatic build_packet(input pkt_spec_t s);
    int unsigned h;
    int unsigned l4len;
    int unsigned n;
    int unsigned len;
    logic [15:0] len_field;
    logic [3:0]  nib;
    frame.delete();
    if (s.junk) begin
      for (int i = 0; i <= s.body; i++) frame.push_back($urandom);
    end else begin
      h = s.v6 ? 40 : s.ihl * 4;
      case (s.proto)
        PROTO_TCP:    l4len = (s.doff * 4 < 20) ? 20 : s.doff * 4;
        PROTO_UDP:    l4len = 8;
        PROTO_ICMP:   l4len = 8;
        PROTO_ICMPV6: l4len = 8;
        default:      l4len = 0;
      endcase
      n = h + l4len + s.body;
      if (n < 10) n = 10;
      for (int i = 0; i < n; i++) frame.push_back($urandom);
      frame[0] = $urandom;
      frame[0][7:4] = s.v6 ? VER_IPV6 : VER_IPV4;
      if (!s.v6) begin
        frame[0][3:0] = s.ihl;
        frame[6] = s.frag[15:8];
        frame[7] = s.frag[7:0];
        frame[9] = s.proto;
      end else begin
        frame[6] = s.proto;
      end
      if (s.bad_ver) begin
        do nib = $urandom_range(15); while (nib == VER_IPV4 || nib == VER_IPV6);
        frame[0][7:4] = nib;
      end
      case (s.proto)
        PROTO_TCP: begin
          put_byte(h + 2, s.dport[15:8]);
          put_byte(h + 3, s.dport[7:0]);
          put_byte(h + 12, {s.doff, 4'(frame[n - 1])});
          put_byte(h + 13, s.flags);
        end
        PROTO_UDP: begin
          put_byte(h + 2, s.dport[15:8]);
          put_byte(h + 3, s.dport[7:0]);
          put_byte(h + 4, s.ulen[15:8]);
          put_byte(h + 5, s.ulen[7:0]);
        end
        PROTO_ICMP, PROTO_ICMPV6: put_byte(h, s.l4_type);
        default: ;
      endcase
      for (int i = 0; i < s.trim && frame.size() > 10; i++) void'(frame.pop_back());
      len = frame.size() + s.len_add - s.len_sub;
      if (s.v6) begin
        len_field = 16'(len - 40);
        frame[4] = len_field[15:8];
        frame[5] = len_field[7:0];
      end else begin
        len_field = 16'(len);
        frame[2] = len_field[15:8];
        frame[3] = len_field[7:0];
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input logic prio);
    while (!steady && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    packet_byte   <= b;
    last_byte     <= last;
    priority_high <= prio;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent_bytes++;
  endtask

  task automatic run_packet(input pkt_spec_t s);
    int unsigned last_idx;
    build_packet(s);
    last_idx = frame.size() - 1;
    for (int unsigned i = 0; i <= last_idx; i++) begin
      if (i == last_idx) send_byte(frame[i], 1'b1, s.prio);
      else send_byte(frame[i], 1'b0, $urandom);
    end
    sent_pkts++;
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // ports change only with the pipeline drained
  task automatic set_ports(input logic [15:0] ftp, input logic [15:0] dns);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(CFG_FTP_PORT, ftp);
    write_reg(CFG_DNS_PORT, dns);
    cfg_we  <= 1'b0;
    cur_ftp = ftp;
    cur_dns = dns;
    settings++;
  endtask

  initial begin
    pkt_spec_t s;
    int        phase_bytes;
    int        phase_pkts;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = CFG_FTP_PORT;
    cfg_data      = '0;
    in_valid      = 1'b0;
    packet_byte   = '0;
    last_byte     = 1'b0;
    priority_high = 1'b0;
    steady        = 1'b0;
    cur_ftp       = FTP_PORT_RESET;
    cur_dns       = DNS_PORT_RESET;
    sent_pkts     = 0;
    sent_bytes    = 0;
    settings      = 1;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: one of each class plus the length corners
    s = plain_spec(1'b0, PROTO_OTHER);  run_packet(s);
    s.body = 1;                         run_packet(s);
    s = plain_spec(1'b0, PROTO_TCP);    s.bad_ver = 1'b1;       run_packet(s);
    s = plain_spec(1'b0, PROTO_TCP);    s.prio = 1'b1;          run_packet(s);
    s = plain_spec(1'b0, PROTO_TCP);    s.flags = 8'hFF;        run_packet(s);
    s.flags = 8'hD0;                    run_packet(s);
    s.flags = 8'hC0;                    run_packet(s);
    s.body = 6;                         s.dport = cur_ftp;      run_packet(s);
    s = plain_spec(1'b1, PROTO_TCP);    s.body = 3;
    s.doff = 4'hF;                      s.dport = 16'hFFFF;     run_packet(s);
    s = plain_spec(1'b0, PROTO_UDP);    s.dport = cur_dns;
    s.ulen = 16'hFFFF;                  run_packet(s);
    s = plain_spec(1'b1, PROTO_UDP);    s.dport = 16'h0000;     run_packet(s);
    s.ulen = UDP_MIN_LEN - 1;           run_packet(s);
    s = plain_spec(1'b0, PROTO_ICMP);   run_packet(s);
    s.l4_type = ICMP_ECHO_REPLY;        run_packet(s);
    s.frag = 16'hFFFF;                  run_packet(s);
    s.frag = 16'hE000;                  s.l4_type = ICMP_TYPE_OTHER; run_packet(s);
    s = plain_spec(1'b1, PROTO_ICMPV6); s.l4_type = ICMP6_ECHO_REQ; run_packet(s);
    s.l4_type = ICMP6_ECHO_REP;         run_packet(s);
    s.l4_type = ICMP_ECHO_REQ;          run_packet(s);
    s = plain_spec(1'b0, PROTO_TCP);    s.len_add = 1;          run_packet(s);
    s = plain_spec(1'b0, PROTO_TCP);    s.ihl = 4'hF;
    s.len_sub = 40;                     run_packet(s);
    s = plain_spec(1'b0, PROTO_TCP);    s.ihl = 4'd2;           run_packet(s);
    s = plain_spec(1'b0, PROTO_TCP);    s.doff = 4'hF;
    s.trim = 10;                        run_packet(s);

    // 65536-byte packets: the byte count saturates at its ceiling
    steady = 1'b1;
    s = plain_spec(1'b0, PROTO_TCP);    s.dport = cur_ftp;
    s.body = 16'd65496;                 s.len_sub = 1;          run_packet(s);
    s = plain_spec(1'b1, PROTO_UDP);    s.body = 16'd65488;     run_packet(s);
    steady = 1'b0;

    for (int phase = 1; phase <= 5; phase++) begin
      case (phase)
        1: set_ports(16'h0000, 16'hFFFF);
        2: set_ports(16'hFFFF, 16'h0000);
        default: set_ports($urandom, $urandom);
      endcase
      steady      = (phase == 3);
      phase_bytes = sent_bytes;
      phase_pkts  = 0;
      while (phase_pkts < 12 || sent_bytes - phase_bytes < 200) begin
        run_packet(random_spec());
        phase_pkts++;
      end
      steady = 1'b0;
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("Sent %0d packets (%0d bytes) under %0d port settings, two at 64 KiB",
             sent_pkts, sent_bytes, settings);
    $display("Checked %0d class codes, %0d mismatches", checked, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
